FILE: sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types, constants and functions of the UTF-8 decoder
//
// This package holds the status codes, the field widths and the lead byte
// classification that the decoder pipeline and its range checker use.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int ByteW = 8;
  localparam int CpW   = 21;
  localparam int LenW  = 3;
  localparam int StatW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [StatW-1:0] stat_t;

  // Status codes of a result.
  localparam stat_t ST_OK       = 2'd0;
  localparam stat_t ST_BAD_SEQ  = 2'd1;
  localparam stat_t ST_BAD_CHAR = 2'd2;

  // Sequence lengths implied by a lead byte.
  localparam len_t LEN_BAD = 3'd0;
  localparam len_t LEN_1   = 3'd1;
  localparam len_t LEN_2   = 3'd2;
  localparam len_t LEN_3   = 3'd3;
  localparam len_t LEN_4   = 3'd4;

  // First value above the Unicode range.
  localparam cp_t CP_LIMIT = 21'h110000;

  // Classifies a lead byte. C0, C1, continuation bytes and F5-FF cannot
  // start a character.
  function automatic len_t lead_length(input byte_t b);
    len_t len;
    len = LEN_BAD;
    if (b[7] == 1'b0) begin
      len = LEN_1;
    end else if (b == 8'hc0 || b == 8'hc1 || b >= 8'hf5) begin
      len = LEN_BAD;
    end else if (b[7:3] == 5'b11110) begin
      len = LEN_4;
    end else if (b[7:4] == 4'b1110) begin
      len = LEN_3;
    end else if (b[7:5] == 3'b110) begin
      len = LEN_2;
    end
    return len;
  endfunction

  // True for a continuation byte of the form 10xxxxxx.
  function automatic logic is_cont(input byte_t b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

FILE: sv/u8d_range_chk.sv
// ----------------------------------------------------------------------------
// u8d_range_chk: scalar value check
//
// Flags an assembled value that is a surrogate, one of the two noncharacters
// FFFE and FFFF, or a value beyond the Unicode range.
// ----------------------------------------------------------------------------
module u8d_range_chk
  import u8d_pkg::*;
(
  input  cp_t  cp,
  output logic bad
);

  logic is_surrogate;
  logic is_nonchar;
  logic is_too_big;

  // Surrogates occupy D800-DFFF, which shares the upper ten bits.
  assign is_surrogate = (cp[CpW-1:11] == 10'b00000_11011);
  // FFFE and FFFF differ only in the lowest bit.
  assign is_nonchar   = (cp[CpW-1:1] == 20'h07fff);
  assign is_too_big   = (cp >= CP_LIMIT);

  assign bad = is_surrogate | is_nonchar | is_too_big;

endmodule

FILE: sv/utf8_char_decoder.sv
// ----------------------------------------------------------------------------
// utf8_char_decoder: one UTF-8 character per cycle
//
// Decodes a four-byte window that starts at a UTF-8 lead byte into a code
// point, a sequence length and a status.
// ----------------------------------------------------------------------------
// A window is transferred at every clock edge where start is high; busy is
// always low, so one character can enter each cycle. The result appears on
// the out_ ports with out_valid high for exactly one cycle, after the three
// pipeline stages (lead classification and continuation check, code point
// assembly, range check). Results leave in the order the windows entered.
// The receiver cannot stall the block, and nothing in it needs holding off.
// On any error out_code_point is zero.
// ----------------------------------------------------------------------------
module utf8_char_decoder
  import u8d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  byte_t in_lead_byte,
  input  byte_t in_second_byte,
  input  byte_t in_third_byte,
  input  byte_t in_fourth_byte,
  output logic  out_valid,
  output cp_t   out_code_point,
  output len_t  out_seq_length,
  output stat_t out_status
);

  // Stage registers.
  logic       v1_r, v1_nxt;
  len_t       len1_r;
  logic       err1_r;
  logic [6:0] lead1_r;
  logic [5:0] c1_r, c2_r, c3_r;

  logic       v2_r, v2_nxt;
  len_t       len2_r;
  logic       err2_r;
  cp_t        cp2_r;

  logic       v3_r, v3_nxt;
  len_t       len3_r;
  stat_t      stat3_r;
  cp_t        cp3_r;

  len_t       len_s1;
  logic       err_s1;
  cp_t        cp_s2;
  logic       bad_s3;
  stat_t      stat_s3;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: classify the lead byte and check the continuation bytes that
  // the length calls for.
  always_comb begin
    len_s1 = lead_length(in_lead_byte);
    err_s1 = 1'b0;
    case (len_s1)
      LEN_1: err_s1 = 1'b0;
      LEN_2: err_s1 = !is_cont(in_second_byte);
      LEN_3: err_s1 = !is_cont(in_second_byte) || !is_cont(in_third_byte);
      LEN_4: err_s1 = !is_cont(in_second_byte) || !is_cont(in_third_byte)
                      || !is_cont(in_fourth_byte);
      default: err_s1 = 1'b1;
    endcase
  end

  // Stage 2: append the continuation payloads to the lead payload.
  always_comb begin
    case (len1_r)
      LEN_1:   cp_s2 = {14'd0, lead1_r};
      LEN_2:   cp_s2 = {10'd0, lead1_r[4:0], c1_r};
      LEN_3:   cp_s2 = {5'd0, lead1_r[3:0], c1_r, c2_r};
      LEN_4:   cp_s2 = {lead1_r[2:0], c1_r, c2_r, c3_r};
      default: cp_s2 = '0;
    endcase
  end

  // Stage 3: reject values outside the scalar range.
  u8d_range_chk u_range_chk (
    .cp  (cp2_r),
    .bad (bad_s3)
  );

  always_comb begin
    if (err2_r) begin
      stat_s3 = ST_BAD_SEQ;
    end else if (bad_s3) begin
      stat_s3 = ST_BAD_CHAR;
    end else begin
      stat_s3 = ST_OK;
    end
  end

  // Valid bits follow the data through the stages.
  assign v1_nxt = start;
  assign v2_nxt = v1_r;
  assign v3_nxt = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    len1_r  <= len_s1;
    err1_r  <= err_s1;
    lead1_r <= in_lead_byte[6:0];
    c1_r    <= in_second_byte[5:0];
    c2_r    <= in_third_byte[5:0];
    c3_r    <= in_fourth_byte[5:0];

    len2_r  <= len1_r;
    err2_r  <= err1_r;
    cp2_r   <= cp_s2;

    len3_r  <= len2_r;
    stat3_r <= stat_s3;
    cp3_r   <= (stat_s3 == ST_OK) ? cp2_r : '0;
  end

  assign out_valid      = v3_r;
  assign out_code_point = cp3_r;
  assign out_seq_length = len3_r;
  assign out_status     = stat3_r;

  // Every transfer yields a result, and no result comes without one.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 out_valid)
    else $error("result missing three cycles after transfer");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result without a transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_code_point == '0)
    else $error("nonzero code point on error");

  a_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_seq_length == LEN_BAD) |-> out_status == ST_BAD_SEQ)
    else $error("invalid lead not reported as bad sequence");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> out_code_point < CP_LIMIT)
    else $error("accepted code point beyond range");

endmodule
